FILE: sv/pif_pkg.sv
package pif_pkg;

    // ascii codes recognised in the format stream or written to the output
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_C     = 8'h63;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_A     = 8'h61;

    // argument is 32 bits wide, so the magnitude never exceeds that
    localparam int MAX_MAG_BITS = 32;
    // ten decimal digits cover any 32-bit magnitude
    localparam int DEC_DIGITS   = 10;
    localparam int DIGIT_BITS   = 4 * DEC_DIGITS;
    localparam int NDIG_W       = $clog2(DEC_DIGITS + 1);

    localparam int QUEUE_DEPTH  = 2;

    typedef enum logic [1:0] {
        K_CHAR1 = 2'd0,   // one character
        K_CHAR2 = 2'd1,   // '%' then the character
        K_DEC   = 2'd2,   // decimal number
        K_HEX   = 2'd3    // hex number
    } kind_t;

    typedef struct packed {
        kind_t                    kind;
        logic                     neg;
        logic [7:0]               ch;
        logic [MAX_MAG_BITS-1:0]  mag;
    } cmd_t;

    function automatic logic [7:0] digit_char(input logic [3:0] nib);
        logic [7:0] wide;
        wide = {4'b0000, nib};
        if (nib < 4'd10)
        begin
            return CH_ZERO + wide;
        end
        return CH_A + wide - 8'd10;
    endfunction

endpackage

FILE: sv/pif_front.sv
module pif_front #(
    parameter int VALUE_BITS = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           fmt_valid,
    output logic           fmt_stall,
    input  logic [7:0]     fmt_byte,
    input  logic [31:0]    arg_word,
    input  logic           q_full,
    output logic           push,
    output pif_pkg::cmd_t  cmd
);
    import pif_pkg::*;

    localparam int MAG_BITS = (VALUE_BITS < MAX_MAG_BITS) ? VALUE_BITS : MAX_MAG_BITS;
    localparam bit SIGN_USED = (VALUE_BITS <= MAX_MAG_BITS);

    logic                pending_reg;
    logic                pending_next;
    logic                accept;
    logic [MAG_BITS-1:0] val;
    logic [MAG_BITS-1:0] val_neg;
    logic                neg;

    assign fmt_stall = q_full;
    assign accept    = fmt_valid && !q_full;

    assign val     = arg_word[MAG_BITS-1:0];
    assign val_neg = ~val + MAG_BITS'(1);
    assign neg     = SIGN_USED && val[MAG_BITS-1];

    assign pending_next = accept ? (!pending_reg && (fmt_byte == CH_PCT)) : pending_reg;
    assign push = accept && (fmt_byte != CH_NUL) && (pending_reg || (fmt_byte != CH_PCT));

    always_comb
    begin
        cmd      = '0;
        cmd.kind = K_CHAR1;
        cmd.ch   = fmt_byte;
        if (pending_reg)
        begin
            case (fmt_byte)
                CH_D, CH_I:
                begin
                    cmd.kind = K_DEC;
                    cmd.neg  = neg;
                    cmd.mag  = MAX_MAG_BITS'(neg ? val_neg : val);
                end
                CH_U:
                begin
                    cmd.kind = K_DEC;
                    cmd.mag  = MAX_MAG_BITS'(val);
                end
                CH_X:
                begin
                    cmd.kind = K_HEX;
                    cmd.mag  = MAX_MAG_BITS'(val);
                end
                CH_C:
                begin
                    cmd.ch = arg_word[7:0];
                end
                CH_PCT:
                begin
                    cmd.ch = CH_PCT;
                end
                default:
                begin
                    cmd.kind = K_CHAR2;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 1'b0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

endmodule

FILE: sv/pif_queue.sv
module pif_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  pif_pkg::cmd_t  push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output pif_pkg::cmd_t  head_cmd
);
    import pif_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: sv/pif_back.sv
module pif_back #(
    parameter int MAG_BITS = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           head_valid,
    input  pif_pkg::cmd_t  head_cmd,
    output logic           pop,
    output logic           chr_valid,
    input  logic           chr_stall,
    output logic [7:0]     out_byte,
    output logic           last_of_run
);
    import pif_pkg::*;

    localparam int CNT_W = $clog2(MAG_BITS + 1);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_PCT  = 7'b0000010,
        S_CHAR = 7'b0000100,
        S_CONV = 7'b0001000,
        S_SIGN = 7'b0010000,
        S_SKIP = 7'b0100000,
        S_DIG  = 7'b1000000
    } state_t;

    state_t                   state_reg;
    state_t                   state_next;
    logic                     neg_reg;
    logic                     neg_next;
    logic [7:0]               ch_reg;
    logic [7:0]               ch_next;
    logic [MAX_MAG_BITS-1:0]  shift_reg;
    logic [MAX_MAG_BITS-1:0]  shift_next;
    logic [DIGIT_BITS-1:0]    digits_reg;
    logic [DIGIT_BITS-1:0]    digits_next;
    logic [DIGIT_BITS-1:0]    adj;
    logic [NDIG_W-1:0]        ndig_reg;
    logic [NDIG_W-1:0]        ndig_next;
    logic [CNT_W-1:0]         cnt_reg;
    logic [CNT_W-1:0]         cnt_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic [7:0]               out_byte_reg;
    logic [7:0]               out_byte_next;
    logic                     last_reg;
    logic                     last_next;
    logic                     out_free;
    logic                     emit;
    logic [3:0]               top_nib;

    assign chr_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign last_of_run = last_reg;
    assign out_free    = !out_valid_reg || !chr_stall;
    assign top_nib     = digits_reg[DIGIT_BITS-1 -: 4];

    // double-dabble correction, one per bcd digit
    always_comb
    begin
        for (int i = 0; i < DEC_DIGITS; i++)
        begin
            adj[4*i +: 4] = (digits_reg[4*i +: 4] >= 4'd5) ?
                            digits_reg[4*i +: 4] + 4'd3 : digits_reg[4*i +: 4];
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        neg_next      = neg_reg;
        ch_next       = ch_reg;
        shift_next    = shift_reg;
        digits_next   = digits_reg;
        ndig_next     = ndig_reg;
        cnt_next      = cnt_reg;
        pop           = 1'b0;
        emit          = 1'b0;
        out_byte_next = out_byte_reg;
        last_next     = last_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (head_valid)
                begin
                    pop       = 1'b1;
                    ch_next   = head_cmd.ch;
                    neg_next  = head_cmd.neg;
                    ndig_next = NDIG_W'(DEC_DIGITS);
                    case (head_cmd.kind)
                        K_CHAR1: state_next = S_CHAR;
                        K_CHAR2: state_next = S_PCT;
                        K_DEC:
                        begin
                            shift_next  = head_cmd.mag << (MAX_MAG_BITS - MAG_BITS);
                            digits_next = '0;
                            cnt_next    = CNT_W'(MAG_BITS);
                            state_next  = S_CONV;
                        end
                        default:
                        begin
                            digits_next = DIGIT_BITS'(head_cmd.mag);
                            state_next  = S_SKIP;
                        end
                    endcase
                end
            end
            S_PCT:
            begin
                if (out_free)
                begin
                    emit          = 1'b1;
                    out_byte_next = CH_PCT;
                    last_next     = 1'b0;
                    state_next    = S_CHAR;
                end
            end
            S_CHAR:
            begin
                if (out_free)
                begin
                    emit          = 1'b1;
                    out_byte_next = ch_reg;
                    last_next     = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_CONV:
            begin
                digits_next = {adj[DIGIT_BITS-2:0], shift_reg[MAX_MAG_BITS-1]};
                shift_next  = {shift_reg[MAX_MAG_BITS-2:0], 1'b0};
                cnt_next    = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = neg_reg ? S_SIGN : S_SKIP;
                end
            end
            S_SIGN:
            begin
                if (out_free)
                begin
                    emit          = 1'b1;
                    out_byte_next = CH_MINUS;
                    last_next     = 1'b0;
                    state_next    = S_SKIP;
                end
            end
            S_SKIP:
            begin
                // drop leading zeros, keeping at least one digit
                if ((top_nib == 4'd0) && (ndig_reg > NDIG_W'(1)))
                begin
                    digits_next = {digits_reg[DIGIT_BITS-5:0], 4'd0};
                    ndig_next   = ndig_reg - NDIG_W'(1);
                end
                else
                begin
                    state_next = S_DIG;
                end
            end
            S_DIG:
            begin
                if (out_free)
                begin
                    emit          = 1'b1;
                    out_byte_next = digit_char(top_nib);
                    last_next     = (ndig_reg == NDIG_W'(1));
                    digits_next   = {digits_reg[DIGIT_BITS-5:0], 4'd0};
                    ndig_next     = ndig_reg - NDIG_W'(1);
                    if (ndig_reg == NDIG_W'(1))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!chr_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg      <= neg_next;
        ch_reg       <= ch_next;
        shift_reg    <= shift_next;
        digits_reg   <= digits_next;
        ndig_reg     <= ndig_next;
        cnt_reg      <= cnt_next;
        out_byte_reg <= out_byte_next;
        last_reg     <= last_next;
    end

endmodule

FILE: sv/printf_integer_formatter.sv
// printf-style integer formatter. format bytes arrive one word at a time on the fmt
// channel, each with a 32-bit argument; ascii characters leave one word at a time on
// the chr channel, with last_of_run marking the final character caused by an input
// byte. a front stage classifies each byte and tracks the pending '%', a two-entry
// command queue decouples it from the back stage, which produces the characters.
// in the back stage a plain byte is loaded and then gives its character; '%' followed
// by another byte gives two characters, '%' and then that byte; %x loads the value,
// skips leading zero nibbles and gives the hex digits, keeping at least one digit;
// %d, %i and %u first run the shift-and-add-3 binary-to-bcd unit over the
// min(VALUE_BITS, 32) magnitude bits, then give a minus sign if negative, skip
// leading zeros and give the digits. the bcd unit and the single character output
// register set the rate; the queue lets up to two commands wait. bytes that produce
// nothing ('%', zero byte) are taken at the front without queueing a command.
module printf_integer_formatter #(
    parameter int VALUE_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    // format byte channel
    input  logic        fmt_valid,
    output logic        fmt_stall,
    input  logic [7:0]  fmt_byte,
    input  logic [31:0] arg_word,
    // character channel
    output logic        chr_valid,
    input  logic        chr_stall,
    output logic [7:0]  out_byte,
    output logic        last_of_run
);
    import pif_pkg::*;

    // magnitude never exceeds the 32-bit argument
    localparam int MAG_BITS = (VALUE_BITS < MAX_MAG_BITS) ? VALUE_BITS : MAX_MAG_BITS;

    logic q_full;
    logic push;
    cmd_t push_cmd;
    logic pop;
    logic head_valid;
    cmd_t head_cmd;

    // classify bytes, hold the pending percent flag
    pif_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .fmt_valid (fmt_valid),
        .fmt_stall (fmt_stall),
        .fmt_byte  (fmt_byte),
        .arg_word  (arg_word),
        .q_full    (q_full),
        .push      (push),
        .cmd       (push_cmd)
    );

    // short command queue between the two halves
    pif_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    // conversion and character output
    pif_back #(
        .MAG_BITS (MAG_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_cmd    (head_cmd),
        .pop         (pop),
        .chr_valid   (chr_valid),
        .chr_stall   (chr_stall),
        .out_byte    (out_byte),
        .last_of_run (last_of_run)
    );

endmodule
